FILE: hw/rtl/dsf_pkg.sv
// shared types and constants of the dirty segment finder
`default_nettype none

package dsf_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_COLUMN_OFFSET = 1'b0,
    CFG_GAP_LIMIT     = 1'b1
  } dsf_cfg_e;

  localparam int unsigned CfgDataW        = 7;
  localparam int unsigned ColumnOffsetW   = 4;
  localparam int unsigned GapLimitW       = 7;
  localparam int unsigned StartW          = 11;
  localparam int unsigned CountW          = 11;

  localparam logic [ColumnOffsetW-1:0] ColumnOffsetReset = 4'd2;
  localparam logic [GapLimitW-1:0]     GapLimitReset     = 7'd8;

  localparam logic [7:0] PageBase    = 8'hB0;
  // 0x10 plus a three-bit nibble is 5'b10xxx
  localparam logic [1:0] ColHighBase = 2'b10;
  localparam int         RowEndCol   = 127;

  // control bits of the item in the compare stage
  typedef struct packed {
    logic valid;
    logic changed;
    logic frame_end;
    logic row_end;
  } dsf_beat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dsf_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module dsf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no new read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dsf_run.sv
// open-run tracker and result register of the dirty segment finder
`default_nettype none

module dsf_run import dsf_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 1024,
  parameter int unsigned ROW_BYTES   = 128,
  localparam int unsigned PosW = $clog2(FRAME_BYTES + 1),
  localparam int unsigned RowW = $clog2(FRAME_BYTES / ROW_BYTES + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [ColumnOffsetW-1:0] column_offset_i,
  input  wire logic [GapLimitW-1:0]     gap_limit_i,
  input  wire dsf_beat_t                beat_i,
  input  wire logic [PosW-1:0]          pos_i,
  input  wire logic [RowW-1:0]          row_i,
  output logic                          advance_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          init_needed_o,
  output logic [7:0]                    page_command_o,
  output logic [3:0]                    column_low_command_o,
  output logic [4:0]                    column_high_command_o,
  output logic [StartW-1:0]             start_position_o,
  output logic [CountW-1:0]             byte_count_o
);

  localparam logic [PosW-1:0] FirstReset    = PosW'(FRAME_BYTES);
  localparam logic [RowW-1:0] FirstRowReset = RowW'(FRAME_BYTES / ROW_BYTES);

  logic [PosW-1:0] first_q, first_d, first_n;
  logic [RowW-1:0] first_row_q, first_row_d, first_row_n;
  logic [PosW-1:0] last_q, last_d, last_n;
  logic            init_q, init_d;
  logic            out_valid_q, out_valid_d;

  logic              init_out_q;
  logic [7:0]        page_q;
  logic [3:0]        col_low_q;
  logic [4:0]        col_high_q;
  logic [StartW-1:0] start_q;
  logic [CountW-1:0] count_q;

  logic            fire;
  logic            hit;
  logic [PosW:0]   gap_end;
  logic            close;
  logic [6:0]      col7;

  assign advance_o = !out_valid_q || out_ready_i;
  assign fire      = beat_i.valid && advance_o;
  assign hit       = beat_i.valid && beat_i.changed;

  always_comb begin
    first_n     = first_q;
    first_row_n = first_row_q;
    last_n      = last_q;
    if (hit && (first_q > pos_i)) begin
      first_n     = pos_i;
      first_row_n = row_i;
    end
    if (hit && (last_q < pos_i)) begin
      last_n = pos_i;
    end
  end

  assign gap_end = {1'b0, last_n} + (PosW + 1)'(gap_limit_i);
  assign close   = (last_n != '0) &&
                   (({1'b0, pos_i} > gap_end) || beat_i.row_end || beat_i.frame_end);
  assign col7    = first_n[6:0] + {3'b000, column_offset_i};

  always_comb begin
    first_d     = first_q;
    first_row_d = first_row_q;
    last_d      = last_q;
    init_d      = init_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    if (fire) begin
      first_d     = first_n;
      first_row_d = first_row_n;
      last_d      = last_n;
      if (close || beat_i.frame_end) begin
        first_d     = FirstReset;
        first_row_d = FirstRowReset;
        last_d      = '0;
      end
      if (close) begin
        init_d      = 1'b0;
        out_valid_d = 1'b1;
      end
      if (beat_i.frame_end) begin
        init_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= FirstReset;
      first_row_q <= FirstRowReset;
      last_q      <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      first_row_q <= first_row_d;
      last_q      <= last_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && close) begin
      init_out_q <= init_q;
      page_q     <= PageBase + 8'(first_row_n);
      col_low_q  <= col7[3:0];
      col_high_q <= {ColHighBase, col7[6:4]};
      start_q    <= StartW'(first_n);
      count_q    <= CountW'(last_n - first_n + PosW'(1));
    end
  end

  assign out_valid_o           = out_valid_q;
  assign init_needed_o         = init_out_q;
  assign page_command_o        = page_q;
  assign column_low_command_o  = col_low_q;
  assign column_high_command_o = col_high_q;
  assign start_position_o      = start_q;
  assign byte_count_o          = count_q;

  // an open run never starts after its last change
  a_run_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_q != '0) |-> (first_q <= last_q))
    else $error("open run has first change after last change");

  // a closed run leaves no open run behind
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && close) |=> (last_q == '0))
    else $error("run still open after close");

  // init flag is set again by every frame end
  a_init_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && beat_i.frame_end) |=> init_q)
    else $error("init flag not rearmed at frame end");

endmodule

`default_nettype wire

FILE: hw/rtl/dirty_segment_finder_core.sv
// top level of the dirty segment finder: scan stage, shadow ram and run tracker
`default_nettype none

// Takes one framebuffer byte per cycle and gives one result per cycle at the
// most. An accepted byte reads its shadow entry in the cycle it is taken, is
// compared in the compare stage and written back when that stage fires, and
// its result is then registered in the output register. The shadow is a
// single ram with one read and one write port; a fill count of the highest
// position seen since reset marks which entries hold data, so there is no
// clearing pass after reset, and a one-entry forward covers a read of the
// entry written in the same cycle (a frame only one byte long). Input ready
// drops only while the output register holds a result that has not been taken.
module dirty_segment_finder_core import dsf_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 1024,
  parameter int unsigned ROW_BYTES   = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          frame_byte_i,
  input  wire logic                end_of_frame_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     init_needed_o,
  output logic [7:0]               page_command_o,
  output logic [3:0]               column_low_command_o,
  output logic [4:0]               column_high_command_o,
  output logic [StartW-1:0]        start_position_o,
  output logic [CountW-1:0]        byte_count_o
);

  localparam int unsigned PosW  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned RowW  = $clog2(FRAME_BYTES / ROW_BYTES + 1);
  localparam int unsigned ColW  = $clog2(ROW_BYTES);
  localparam int unsigned AddrW = $clog2(FRAME_BYTES);

  // configuration
  logic [ColumnOffsetW-1:0] column_offset_q;
  logic [GapLimitW-1:0]     gap_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_offset_q <= ColumnOffsetReset;
      gap_limit_q     <= GapLimitReset;
    end else if (cfg_we_i) begin
      case (dsf_cfg_e'(cfg_index_i))
        CFG_COLUMN_OFFSET: column_offset_q <= cfg_data_i[ColumnOffsetW-1:0];
        CFG_GAP_LIMIT:     gap_limit_q     <= cfg_data_i[GapLimitW-1:0];
        default: ;
      endcase
    end
  end

  // scan stage
  logic [PosW-1:0] pos_q, pos_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [PosW-1:0] fill_q, fill_d;
  logic            accept;
  logic            frame_end;
  logic            row_end;

  // compare stage
  logic            s1_valid_q, s1_valid_d;
  logic [PosW-1:0] s1_pos_q;
  logic [RowW-1:0] s1_row_q;
  logic [7:0]      s1_byte_q;
  logic            s1_frame_end_q;
  logic            s1_row_end_q;
  logic            s1_shadow_ok_q;
  logic            s1_fwd_q;
  logic [7:0]      s1_fwd_data_q;
  logic            s1_fire;
  logic [7:0]      shadow_byte;
  dsf_beat_t       beat;
  logic            advance;

  // shadow ram ports
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;

  assign s1_fire    = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign frame_end  = end_of_frame_i || (pos_q >= PosW'(FRAME_BYTES));
  assign row_end    = (int'(col_q) == RowEndCol);

  always_comb begin
    pos_d  = pos_q;
    col_d  = col_q;
    row_d  = row_q;
    fill_d = fill_q;
    if (accept) begin
      if (pos_q > fill_q) begin
        fill_d = pos_q;
      end
      if (frame_end) begin
        pos_d = PosW'(1);
        col_d = ColW'(1);
        row_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
        if (col_q == ColW'(ROW_BYTES - 1)) begin
          col_d = '0;
          row_d = row_q + RowW'(1);
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= PosW'(1);
      col_q      <= ColW'(1);
      row_q      <= '0;
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      col_q      <= col_d;
      row_q      <= row_d;
      fill_q     <= fill_d;
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        s1_fwd_q <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  assign s1_valid_d = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q       <= pos_q;
      s1_row_q       <= row_q;
      s1_byte_q      <= frame_byte_i;
      s1_frame_end_q <= frame_end;
      s1_row_end_q   <= row_end;
      s1_shadow_ok_q <= (pos_q <= fill_q);
      s1_fwd_data_q  <= s1_byte_q;
    end
  end

  // every beat writes its byte back, so a visited entry always holds data
  assign wr_en   = s1_fire;
  assign wr_addr = AddrW'(s1_pos_q - PosW'(1));
  assign rd_addr = AddrW'(pos_q - PosW'(1));

  dsf_ram #(
    .Width(8),
    .Depth(FRAME_BYTES)
  ) u_shadow (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(s1_byte_q),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_comb begin
    if (s1_fwd_q) begin
      shadow_byte = s1_fwd_data_q;
    end else if (s1_shadow_ok_q) begin
      shadow_byte = rd_data;
    end else begin
      shadow_byte = 8'h00;
    end
  end

  assign beat.valid     = s1_valid_q;
  assign beat.changed   = (shadow_byte != s1_byte_q);
  assign beat.frame_end = s1_frame_end_q;
  assign beat.row_end   = s1_row_end_q;

  dsf_run #(
    .FRAME_BYTES(FRAME_BYTES),
    .ROW_BYTES  (ROW_BYTES)
  ) u_run (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .column_offset_i      (column_offset_q),
    .gap_limit_i          (gap_limit_q),
    .beat_i               (beat),
    .pos_i                (s1_pos_q),
    .row_i                (s1_row_q),
    .advance_o            (advance),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .init_needed_o        (init_needed_o),
    .page_command_o       (page_command_o),
    .column_low_command_o (column_low_command_o),
    .column_high_command_o(column_high_command_o),
    .start_position_o     (start_position_o),
    .byte_count_o         (byte_count_o)
  );

  // a forwarded entry was visited before, so the fill count covers it
  a_fwd_within_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_fwd_q) |-> s1_shadow_ok_q)
    else $error("forward hit on an entry outside the fill count");

  // scan position stays within the frame
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != '0) && (pos_q <= PosW'(FRAME_BYTES)))
    else $error("scan position out of range");

  // fill count covers every accepted position
  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (fill_q >= $past(pos_q)))
    else $error("fill count behind accepted position");

endmodule

`default_nettype wire
